// ===== design/thadc_pkg.sv =====
package thadc_pkg;

    localparam int ADC_W        = 12;
    localparam int TABLE_POINTS = 17;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int RES_W        = 23;
    localparam int FRAC_BITS    = 16;
    localparam int VN_W         = 21;
    localparam int PV_W         = 25;
    localparam int PV_SPLIT     = RES_W - FRAC_BITS;
    localparam int TQ_W         = 7;
    localparam int TD_W         = RES_W + TQ_W;
    localparam int TEMP_W       = 11;
    localparam int CNT_W        = $clog2(RES_W + 1);
    localparam int PC_W         = 3;

    localparam int VREF_CV      = 328;
    localparam int SUPPLY_HI_CV = 500;
    localparam int SUPPLY_LO_CV = 326;

    typedef logic [RES_W-1:0] res_t;
    typedef logic signed [TEMP_W-1:0] temp_t;

    localparam res_t RES_TABLE [TABLE_POINTS] = '{
        23'd7995392, 23'd4721213, 23'd2889482, 23'd1825833, 23'd1188168, 23'd967967,
        23'd794296, 23'd655360, 23'd543949, 23'd453509, 23'd380764, 23'd271319,
        23'd197263, 23'd146145, 23'd109445, 23'd83231, 23'd63570
    };

    localparam temp_t TENTHS_TABLE [TABLE_POINTS] = '{
        -11'sd300, -11'sd200, -11'sd100, 11'sd0, 11'sd100, 11'sd150, 11'sd200, 11'sd250,
        11'sd300, 11'sd350, 11'sd400, 11'sd500, 11'sd600, 11'sd700, 11'sd800, 11'sd900,
        11'sd1000
    };

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_PREP_R,
        OP_DIV,
        OP_CHECK,
        OP_SEARCH,
        OP_PREP_T,
        OP_FIN
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_IDLE,
        C_LOOP,
        C_SAT,
        C_MISS
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic cnt_last;
        logic sat;
        logic found;
    } stat_t;

    localparam logic [PC_W-1:0] PC_IDLE   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_PREP_R = PC_W'(1);
    localparam logic [PC_W-1:0] PC_DIV_R  = PC_W'(2);
    localparam logic [PC_W-1:0] PC_CHECK  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_SEARCH = PC_W'(4);
    localparam logic [PC_W-1:0] PC_PREP_T = PC_W'(5);
    localparam logic [PC_W-1:0] PC_DIV_T  = PC_W'(6);
    localparam logic [PC_W-1:0] PC_FIN    = PC_W'(7);

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            PC_IDLE:   w = '{op: OP_LOAD,   cond: C_IDLE,   target: PC_IDLE};
            PC_PREP_R: w = '{op: OP_PREP_R, cond: C_NEXT,   target: PC_IDLE};
            PC_DIV_R:  w = '{op: OP_DIV,    cond: C_LOOP,   target: PC_DIV_R};
            PC_CHECK:  w = '{op: OP_CHECK,  cond: C_SAT,    target: PC_FIN};
            PC_SEARCH: w = '{op: OP_SEARCH, cond: C_MISS,   target: PC_SEARCH};
            PC_PREP_T: w = '{op: OP_PREP_T, cond: C_NEXT,   target: PC_IDLE};
            PC_DIV_T:  w = '{op: OP_DIV,    cond: C_LOOP,   target: PC_DIV_T};
            PC_FIN:    w = '{op: OP_FIN,    cond: C_ALWAYS, target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/thadc_seq.sv =====
module thadc_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  thadc_pkg::stat_t stat,
    output thadc_pkg::ctrl_t ctrl,
    output logic             busy
);
    import thadc_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign ctrl = ucode(pc_reg);
    assign busy = (pc_reg != PC_IDLE);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:   take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_IDLE:   take = !stat.start;
            C_LOOP:   take = !stat.cnt_last;
            C_SAT:    take = stat.sat;
            C_MISS:   take = !stat.found;
            default:  take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== design/thadc_datapath.sv =====
module thadc_datapath #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  thadc_pkg::ctrl_t                    ctrl,
    input  logic                                start,
    input  logic [thadc_pkg::ADC_W-1:0]         adc_sample,
    input  logic                                divider_select,
    output thadc_pkg::stat_t                    stat,
    output logic                                done,
    output logic signed [thadc_pkg::TEMP_W-1:0] temperature_tenths
);
    import thadc_pkg::*;

    localparam int VMAX_HI = (SUPPLY_HI_CV - 1) * ADC_FULL_SCALE;
    localparam int VMAX_LO = (SUPPLY_LO_CV - 1) * ADC_FULL_SCALE;
    localparam int SFS_HI  = SUPPLY_HI_CV * ADC_FULL_SCALE;
    localparam int SFS_LO  = SUPPLY_LO_CV * ADC_FULL_SCALE;
    localparam int D_W     = $clog2(SFS_HI + 1);
    localparam int DV_W    = (D_W > RES_W) ? D_W : RES_W;
    localparam int CMP_W   = (D_W > VN_W) ? D_W : VN_W;

    logic [VN_W-1:0]  vn_reg,   vn_next;
    logic             sel_reg,  sel_next;
    logic [DV_W-1:0]  rem_reg,  rem_next;
    logic [DV_W-1:0]  dvs_reg,  dvs_next;
    res_t             a_reg,    a_next;
    res_t             r_reg,    r_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [IDX_W-1:0] idx_reg,  idx_next;
    logic             ovf_reg,  ovf_next;
    logic             sat_reg,  sat_next;
    temp_t            satv_reg, satv_next;
    temp_t            out_reg,  out_next;
    logic             done_reg, done_next;

    logic [CMP_W-1:0] vmax;
    logic [VN_W-1:0]  vn_c;
    logic [D_W-1:0]   sfs;
    logic [D_W-1:0]   den;
    logic [PV_W-1:0]  pv;
    logic [DV_W+1:0]  diff;
    logic             ge;
    logic             sat_hi;
    logic             sat_lo;
    logic [IDX_W-1:0] idx_p1;
    logic             found;
    res_t             ri;
    res_t             rj;
    res_t             d;
    logic [TQ_W-1:0]  dt10;
    logic [TD_W-1:0]  prod;
    temp_t            base;
    temp_t            sum;
    logic             adj;

    always_comb
    begin
        vmax   = sel_reg ? CMP_W'(VMAX_HI) : CMP_W'(VMAX_LO);
        vn_c   = (CMP_W'(vn_reg) > vmax) ? VN_W'(vmax) : vn_reg;
        sfs    = sel_reg ? D_W'(SFS_HI) : D_W'(SFS_LO);
        den    = sfs - D_W'(vn_c);
        pv     = sel_reg ? ((PV_W'(vn_c) << 4) + (PV_W'(vn_c) << 2))
                         : ((PV_W'(vn_c) << 3) + (PV_W'(vn_c) << 1));

        diff   = {1'b0, rem_reg, a_reg[RES_W-1]} - {2'b00, dvs_reg};
        ge     = !diff[DV_W+1];

        sat_lo = (a_reg <= RES_TABLE[TABLE_POINTS-1]);
        sat_hi = ovf_reg || (a_reg >= RES_TABLE[0]);

        idx_p1 = idx_reg + 1'b1;
        found  = (r_reg >= RES_TABLE[idx_p1]);
        ri     = RES_TABLE[idx_reg];
        rj     = RES_TABLE[idx_p1];
        d      = ri - r_reg;
        dt10   = TQ_W'(TENTHS_TABLE[idx_p1] - TENTHS_TABLE[idx_reg]);
        prod   = TD_W'(dt10) * TD_W'(d);

        base   = TENTHS_TABLE[idx_reg];
        sum    = base + $signed(TEMP_W'(a_reg[TQ_W-1:0]));
        adj    = (rem_reg != '0) && sum[TEMP_W-1];
    end

    always_comb
    begin
        vn_next   = vn_reg;
        sel_next  = sel_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        a_next    = a_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        ovf_next  = ovf_reg;
        sat_next  = sat_reg;
        satv_next = satv_reg;
        out_next  = out_reg;
        done_next = 1'b0;
        unique case (ctrl.op)
            OP_LOAD:
            begin
                if (start)
                begin
                    vn_next  = VN_W'(adc_sample) * VN_W'(VREF_CV);
                    sel_next = divider_select;
                end
            end
            OP_PREP_R:
            begin
                rem_next = DV_W'(pv[PV_W-1:PV_SPLIT]);
                a_next   = {pv[PV_SPLIT-1:0], FRAC_BITS'(0)};
                dvs_next = DV_W'(den);
                ovf_next = (DV_W'(pv[PV_W-1:PV_SPLIT]) >= DV_W'(den));
                cnt_next = CNT_W'(RES_W);
            end
            OP_DIV:
            begin
                rem_next = ge ? diff[DV_W-1:0] : {rem_reg[DV_W-2:0], a_reg[RES_W-1]};
                a_next   = {a_reg[RES_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_CHECK:
            begin
                r_next   = a_reg;
                idx_next = '0;
                priority if (ovf_reg)
                begin
                    sat_next  = 1'b1;
                    satv_next = TENTHS_TABLE[0];
                end
                else if (sat_lo)
                begin
                    sat_next  = 1'b1;
                    satv_next = TENTHS_TABLE[TABLE_POINTS-1];
                end
                else if (sat_hi)
                begin
                    sat_next  = 1'b1;
                    satv_next = TENTHS_TABLE[0];
                end
                else
                begin
                    sat_next  = 1'b0;
                end
            end
            OP_SEARCH:
            begin
                if (!found)
                begin
                    idx_next = idx_p1;
                end
            end
            OP_PREP_T:
            begin
                rem_next = DV_W'(prod[TD_W-1:TQ_W]);
                a_next   = {prod[TQ_W-1:0], (RES_W-TQ_W)'(0)};
                dvs_next = DV_W'(ri - rj);
                cnt_next = CNT_W'(TQ_W);
            end
            OP_FIN:
            begin
                out_next  = sat_reg ? satv_reg : sum + TEMP_W'(adj);
                done_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vn_reg   <= vn_next;
        sel_reg  <= sel_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        a_reg    <= a_next;
        r_reg    <= r_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        ovf_reg  <= ovf_next;
        sat_reg  <= sat_next;
        satv_reg <= satv_next;
        out_reg  <= out_next;
    end

    assign stat.start         = start;
    assign stat.cnt_last      = (cnt_reg == CNT_W'(1));
    assign stat.sat           = sat_lo || sat_hi;
    assign stat.found         = found;
    assign done               = done_reg;
    assign temperature_tenths = out_reg;

endmodule

// ===== design/thermistor_adc_to_temperature.sv =====
// Converts one 12-bit thermistor divider sample into tenths of a degree C. A transaction
// starts when start is high while busy is low; the result shows on temperature_tenths
// with done, which is high for exactly one cycle, and the receiver cannot stall it. When
// the resistance saturates outside the table, the table search and the interpolation
// are skipped. The work is done by one shared restoring divider (23 steps for the
// resistance, 7 for the interpolation) and a table search of one entry per cycle.
// busy drops in the cycle done is shown, so the next sample may be taken there.
module thermistor_adc_to_temperature #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [thadc_pkg::ADC_W-1:0]         adc_sample,
    input  logic                                divider_select,
    output logic                                done,
    output logic signed [thadc_pkg::TEMP_W-1:0] temperature_tenths
);
    import thadc_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    thadc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    thadc_datapath #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .start              (start),
        .adc_sample         (adc_sample),
        .divider_select     (divider_select),
        .stat               (stat),
        .done               (done),
        .temperature_tenths (temperature_tenths)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a transaction in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (temperature_tenths >= TENTHS_TABLE[0]
                  && temperature_tenths <= TENTHS_TABLE[TABLE_POINTS-1]))
        else $error("temperature out of table range");

endmodule
